@@ design/dual_heap_priority_queue_assert.svh @@
// assertion macros for the dual heap priority queue
// used by the top level; expects signals clk and rst in scope
`ifndef DUAL_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define DUAL_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define DHPQ_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dhpq assertion failed");
`define DHPQ_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dhpq assertion failed");
`else
`define DHPQ_ASSERT_IMP(lbl, a, b)
`define DHPQ_ASSERT_NXT(lbl, a, b)
`endif
`endif

@@ design/dhpq_pkg.sv @@
// shared types and codes for the dual heap priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dhpq_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] tag;
    logic [15:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] max_tag;
    logic [15:0] max_priority;
    logic        max_valid;
    logic [31:0] min_tag;
    logic [15:0] min_priority;
    logic        min_valid;
    logic        is_full;
    logic        is_empty;
  } rsp_t;

  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_UPDATE  = 2'd1;
  localparam logic [1:0] FUNC_REM_MAX = 2'd2;
  localparam logic [1:0] FUNC_REM_MIN = 2'd3;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [3:0] OP_IDLE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_SCAN_ST   = 4'd2;
  localparam logic [3:0] OP_SCAN      = 4'd3;
  localparam logic [3:0] OP_SET_PRIO  = 4'd4;
  localparam logic [3:0] OP_DROP      = 4'd5;
  localparam logic [3:0] OP_RD_LAST   = 4'd6;
  localparam logic [3:0] OP_TAKE_LAST = 4'd7;
  localparam logic [3:0] OP_UP_RD     = 4'd8;
  localparam logic [3:0] OP_UP_CMP    = 4'd9;
  localparam logic [3:0] OP_DN_L      = 4'd10;
  localparam logic [3:0] OP_DN_R      = 4'd11;
  localparam logic [3:0] OP_DN_CMP    = 4'd12;
  localparam logic [3:0] OP_WR_CUR    = 4'd13;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] tag;
    logic [15:0] prio;
  } hcmd_t;

  typedef struct packed {
    logic full;
    logic found;
    logic miss;
    logic pos_zero;
    logic pos_last;
    logic up_move;
    logic moved;
    logic has_left;
    logic dn_move;
  } hstat_t;

endpackage
`default_nettype wire

@@ design/dhpq_heap.sv @@
// datapath of one heap: entry memory, count, sift registers and compares
// depends on dhpq_pkg
`timescale 1ns / 1ps
`default_nettype none
module dhpq_heap import dhpq_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int TAG_BITS  = 32,
  parameter int PRIO_BITS = 16,
  parameter bit IS_MAX    = 1'b1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hcmd_t                cmd,
  output hstat_t                    stat,
  output logic [TAG_BITS-1:0]       root_tag,
  output logic [PRIO_BITS-1:0]      root_prio,
  output logic                      nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } ent_t;

  ent_t          mem [DEPTH];
  ent_t          rdata;
  ent_t          cur;
  ent_t          child;
  ent_t          wdata;
  ent_t          root;
  logic [CW-1:0] count;
  logic [CW-1:0] scan;
  logic [AW-1:0] pos;
  logic [AW-1:0] ridx;
  logic          rv;
  logic          moved;
  logic          child_left;
  logic          has_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [AW-1:0] pm1;
  logic [AW-1:0] par;
  logic [XW-1:0] l_ext;
  logic [XW-1:0] r_ext;
  logic [XW-1:0] cnt_ext;
  logic          issue;
  logic          found;
  logic          up_move;
  logic          left_better;
  logic          right_better;
  logic          dn_move;

  function automatic logic better(input logic [PRIO_BITS-1:0] a,
                                  input logic [PRIO_BITS-1:0] b);
    return IS_MAX ? (a > b) : (a < b);
  endfunction

  assign pm1          = pos - AW'(1);
  assign par          = pm1 >> 1;
  assign l_ext        = {1'b0, pos, 1'b1};
  assign r_ext        = l_ext + XW'(1);
  assign cnt_ext      = XW'(count);
  assign issue        = scan < count;
  assign found        = rv && (rdata.tag == cmd.tag[TAG_BITS-1:0]);
  assign up_move      = better(cur.prio, rdata.prio);
  assign left_better  = better(rdata.prio, cur.prio);
  assign right_better = has_r && better(rdata.prio, child.prio);
  assign dn_move      = right_better || child_left;

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    re    = 1'b0;
    raddr = scan[AW-1:0];
    case (cmd.op)
      OP_SCAN: begin
        re = issue;
      end
      OP_RD_LAST: begin
        re    = 1'b1;
        raddr = AW'(count - CW'(1));
      end
      OP_UP_RD: begin
        re    = (pos != '0);
        raddr = par;
      end
      OP_UP_CMP: begin
        we    = up_move;
        wdata = rdata;
      end
      OP_DN_L: begin
        re    = l_ext < cnt_ext;
        raddr = l_ext[AW-1:0];
      end
      OP_DN_R: begin
        re    = r_ext < cnt_ext;
        raddr = r_ext[AW-1:0];
      end
      OP_DN_CMP: begin
        we    = dn_move;
        wdata = right_better ? rdata : child;
      end
      OP_WR_CUR: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rv    <= 1'b0;
      moved <= 1'b0;
      scan  <= '0;
    end else begin
      rv <= (cmd.op == OP_SCAN) && issue;
      case (cmd.op)
        OP_LOAD: begin
          count <= count + CW'(1);
          moved <= 1'b0;
        end
        OP_SCAN_ST: begin
          scan  <= '0;
          moved <= 1'b0;
        end
        OP_SCAN: begin
          if (issue) begin
            scan <= scan + CW'(1);
          end
        end
        OP_DROP, OP_RD_LAST: begin
          count <= count - CW'(1);
        end
        OP_UP_CMP: begin
          if (up_move) begin
            moved <= 1'b1;
          end
        end
        default: begin
          moved <= moved;
        end
      endcase
    end
  end

  // sift payload registers
  always_ff @(posedge clk) begin
    ridx <= scan[AW-1:0];
    case (cmd.op)
      OP_LOAD: begin
        cur.tag  <= cmd.tag[TAG_BITS-1:0];
        cur.prio <= cmd.prio[PRIO_BITS-1:0];
        pos      <= count[AW-1:0];
      end
      OP_SCAN: begin
        if (found) begin
          cur <= rdata;
          pos <= ridx;
        end
      end
      OP_SET_PRIO: begin
        cur.prio <= cmd.prio[PRIO_BITS-1:0];
      end
      OP_TAKE_LAST: begin
        cur <= rdata;
      end
      OP_UP_CMP: begin
        if (up_move) begin
          pos <= par;
        end
      end
      OP_DN_R: begin
        child      <= left_better ? rdata : cur;
        child_left <= left_better;
        has_r      <= r_ext < cnt_ext;
      end
      OP_DN_CMP: begin
        if (dn_move) begin
          pos <= right_better ? r_ext[AW-1:0] : l_ext[AW-1:0];
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  always_comb begin
    stat.full     = (count == CW'(DEPTH));
    stat.found    = found;
    stat.miss     = !found && !issue;
    stat.pos_zero = (pos == '0);
    stat.pos_last = (CW'(pos) == (count - CW'(1)));
    stat.up_move  = up_move;
    stat.moved    = moved;
    stat.has_left = l_ext < cnt_ext;
    stat.dn_move  = dn_move;
  end

  assign root_tag  = root.tag;
  assign root_prio = root.prio;
  assign nonempty  = (count != '0);

endmodule
`default_nettype wire

@@ design/dhpq_ctrl.sv @@
// controller state machine: sequences search, load and sift steps per heap
// depends on dhpq_pkg
`timescale 1ns / 1ps
`default_nettype none
module dhpq_ctrl import dhpq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire req_t   req,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output hcmd_t       cmd_min,
  output hcmd_t       cmd_max,
  input  wire hstat_t st_min,
  input  wire hstat_t st_max
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PICK   = 5'd1;
  localparam logic [4:0] S_LOAD   = 5'd2;
  localparam logic [4:0] S_SCANST = 5'd3;
  localparam logic [4:0] S_SCAN   = 5'd4;
  localparam logic [4:0] S_FOUND  = 5'd5;
  localparam logic [4:0] S_SETP   = 5'd6;
  localparam logic [4:0] S_DROP   = 5'd7;
  localparam logic [4:0] S_RDLAST = 5'd8;
  localparam logic [4:0] S_TAKE   = 5'd9;
  localparam logic [4:0] S_UPRD   = 5'd10;
  localparam logic [4:0] S_UPCMP  = 5'd11;
  localparam logic [4:0] S_DNL    = 5'd12;
  localparam logic [4:0] S_DNR    = 5'd13;
  localparam logic [4:0] S_DNCMP  = 5'd14;
  localparam logic [4:0] S_WR     = 5'd15;
  localparam logic [4:0] S_FIN    = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;

  logic [4:0]  state;
  logic [4:0]  state_next;
  logic [1:0]  func;
  logic [31:0] tag;
  logic [15:0] prio;
  logic        sel;
  logic        hit;
  logic [3:0]  op;
  hstat_t      hs;
  hcmd_t       c;

  assign hs = sel ? st_max : st_min;

  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    case (state)
      S_IDLE: begin
        if (start) begin
          if ((req.func == FUNC_INSERT) && (st_min.full || st_max.full)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_PICK;
          end
        end
      end
      S_PICK: begin
        state_next = (func == FUNC_INSERT) ? S_LOAD : S_SCANST;
      end
      S_LOAD: begin
        op         = OP_LOAD;
        state_next = S_UPRD;
      end
      S_SCANST: begin
        op         = OP_SCAN_ST;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (hs.found) begin
          state_next = S_FOUND;
        end else if (hs.miss) begin
          state_next = S_FIN;
        end
      end
      S_FOUND: begin
        if (func == FUNC_UPDATE) begin
          state_next = S_SETP;
        end else if (hs.pos_last) begin
          state_next = S_DROP;
        end else begin
          state_next = S_RDLAST;
        end
      end
      S_SETP: begin
        op         = OP_SET_PRIO;
        state_next = S_UPRD;
      end
      S_DROP: begin
        op         = OP_DROP;
        state_next = S_FIN;
      end
      S_RDLAST: begin
        op         = OP_RD_LAST;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        op         = OP_TAKE_LAST;
        state_next = S_UPRD;
      end
      S_UPRD: begin
        op = OP_UP_RD;
        if (!hs.pos_zero) begin
          state_next = S_UPCMP;
        end else if (hs.moved) begin
          state_next = S_WR;
        end else begin
          state_next = S_DNL;
        end
      end
      S_UPCMP: begin
        op = OP_UP_CMP;
        if (hs.up_move) begin
          state_next = S_UPRD;
        end else if (hs.moved) begin
          state_next = S_WR;
        end else begin
          state_next = S_DNL;
        end
      end
      S_DNL: begin
        op         = OP_DN_L;
        state_next = hs.has_left ? S_DNR : S_WR;
      end
      S_DNR: begin
        op         = OP_DN_R;
        state_next = S_DNCMP;
      end
      S_DNCMP: begin
        op         = OP_DN_CMP;
        state_next = hs.dn_move ? S_DNL : S_WR;
      end
      S_WR: begin
        op         = OP_WR_CUR;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (((func == FUNC_INSERT) || (func == FUNC_UPDATE)) && !sel) begin
          state_next = S_PICK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sel    <= 1'b0;
      hit    <= 1'b0;
      status <= STATUS_DONE;
      func   <= FUNC_INSERT;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            func   <= req.func;
            hit    <= 1'b0;
            sel    <= (req.func == FUNC_REM_MAX);
            status <= (state_next == S_DONE) ? STATUS_FULL : STATUS_DONE;
          end
        end
        S_FOUND: begin
          hit <= 1'b1;
        end
        S_FIN: begin
          if (state_next == S_PICK) begin
            sel <= 1'b1;
          end else if ((func != FUNC_INSERT) && !hit) begin
            status <= STATUS_NOT_FOUND;
          end
        end
        default: begin
          hit <= hit;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      tag  <= req.tag;
      prio <= req.priority_req;
    end
  end

  always_comb begin
    c.op    = op;
    c.tag   = tag;
    c.prio  = prio;
    cmd_min = c;
    cmd_max = c;
    if (sel) begin
      cmd_min.op = OP_IDLE;
    end else begin
      cmd_max.op = OP_IDLE;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
`default_nettype wire

@@ design/dual_heap_priority_queue.sv @@
// sequencing, from the accepting edge through the result beat:
// a rejected insert goes straight to the result beat; update and removal grow with the tag scan
// per heap: setup steps, a tag scan that reads the entries in turn at one per cycle, then a sift
// up or down a level at a time and a final write to settle; update visits both heaps
// throughput: one command at a time, busy stays high through the result beat, no stall
// reset: synchronous rst empties both heaps; entry memories need no clearing
`timescale 1ns / 1ps
`default_nettype none
`include "dual_heap_priority_queue_assert.svh"
module dual_heap_priority_queue import dhpq_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int TAG_BITS  = 32,
  parameter int PRIO_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output rsp_t      result
);

  // command and status between controller and the two heap datapaths
  hcmd_t  cmd_min;
  hcmd_t  cmd_max;
  hstat_t st_min;
  hstat_t st_max;
  logic [1:0] status;

  // root copies, kept in registers on every write to entry zero
  logic [TAG_BITS-1:0]  max_root_tag;
  logic [PRIO_BITS-1:0] max_root_prio;
  logic                 max_ne;
  logic [TAG_BITS-1:0]  min_root_tag;
  logic [PRIO_BITS-1:0] min_root_prio;
  logic                 min_ne;

  dhpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .status  (status),
    .cmd_min (cmd_min),
    .cmd_max (cmd_max),
    .st_min  (st_min),
    .st_max  (st_max)
  );

  // min heap: smaller priority rises
  dhpq_heap #(
    .DEPTH     (DEPTH),
    .TAG_BITS  (TAG_BITS),
    .PRIO_BITS (PRIO_BITS),
    .IS_MAX    (1'b0)
  ) u_min_heap (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_min),
    .stat      (st_min),
    .root_tag  (min_root_tag),
    .root_prio (min_root_prio),
    .nonempty  (min_ne)
  );

  // max heap: larger priority rises
  dhpq_heap #(
    .DEPTH     (DEPTH),
    .TAG_BITS  (TAG_BITS),
    .PRIO_BITS (PRIO_BITS),
    .IS_MAX    (1'b1)
  ) u_max_heap (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_max),
    .stat      (st_max),
    .root_tag  (max_root_tag),
    .root_prio (max_root_prio),
    .nonempty  (max_ne)
  );

  // empty heaps report zero at the root
  always_comb begin
    result.status       = status;
    result.max_tag      = max_ne ? 32'(max_root_tag) : '0;
    result.max_priority = max_ne ? 16'(max_root_prio) : '0;
    result.max_valid    = max_ne;
    result.min_tag      = min_ne ? 32'(min_root_tag) : '0;
    result.min_priority = min_ne ? 16'(min_root_prio) : '0;
    result.min_valid    = min_ne;
    result.is_full      = st_max.full && st_min.full;
    result.is_empty     = !max_ne && !min_ne;
  end

  `DHPQ_ASSERT_IMP(a_done_while_busy, done, busy)
  `DHPQ_ASSERT_NXT(a_start_goes_busy, start && !busy, busy)
  `DHPQ_ASSERT_NXT(a_done_then_idle, done, !busy)
  `DHPQ_ASSERT_IMP(a_full_not_empty, done && result.is_full, !result.is_empty)

endmodule
`default_nettype wire

@@ test/tb_dual_heap_priority_queue.sv @@
// testbench for the dual heap priority queue: directed table, then random commands
// checked beat by beat against a behavioral model of both heaps
// depends on dhpq_pkg and dual_heap_priority_queue
`timescale 1ns / 1ps
`default_nettype none
module tb_dual_heap_priority_queue;
  import dhpq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] prio;
  } slot_t;

  // one row of the directed table; has_rsp marks a typed-in expected result
  typedef struct {
    req_t cmd;
    logic has_rsp;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t result;

  dual_heap_priority_queue dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state of both heaps
  slot_t hi_heap[DEPTH];
  slot_t lo_heap[DEPTH];
  int hi_n;
  int lo_n;
  rsp_t pending_rsp[$];
  int errors = 0;
  int cycles = 0;
  logic [31:0] live_tags[$];

  function automatic bit wins(bit is_max, logic [15:0] a, logic [15:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  // move the entry at pos up or down until heap order holds
  task automatic resift(bit is_max, int n, int pos);
    int pick;
    slot_t t;
    if (pos >= n) return;
    if (pos > 0 && wins(is_max, is_max ? hi_heap[pos].prio : lo_heap[pos].prio,
        is_max ? hi_heap[(pos-1)/2].prio : lo_heap[(pos-1)/2].prio)) begin
      while (pos > 0 && wins(is_max, is_max ? hi_heap[pos].prio : lo_heap[pos].prio,
          is_max ? hi_heap[(pos-1)/2].prio : lo_heap[(pos-1)/2].prio)) begin
        if (is_max) begin
          t = hi_heap[pos]; hi_heap[pos] = hi_heap[(pos-1)/2]; hi_heap[(pos-1)/2] = t;
        end else begin
          t = lo_heap[pos]; lo_heap[pos] = lo_heap[(pos-1)/2]; lo_heap[(pos-1)/2] = t;
        end
        pos = (pos - 1) / 2;
      end
      return;
    end
    forever begin
      pick = pos;
      for (int c = 2*pos + 1; c <= 2*pos + 2; c++)
        if (c < n && wins(is_max, is_max ? hi_heap[c].prio : lo_heap[c].prio,
            is_max ? hi_heap[pick].prio : lo_heap[pick].prio))
          pick = c;
      if (pick == pos) return;
      if (is_max) begin
        t = hi_heap[pos]; hi_heap[pos] = hi_heap[pick]; hi_heap[pick] = t;
      end else begin
        t = lo_heap[pos]; lo_heap[pos] = lo_heap[pick]; lo_heap[pick] = t;
      end
      pos = pick;
    end
  endtask

  function automatic int find_slot(bit is_max, int n, logic [31:0] tag);
    for (int i = 0; i < n; i++)
      if ((is_max ? hi_heap[i].tag : lo_heap[i].tag) == tag) return i;
    return n;
  endfunction

  task automatic drop_tag(bit is_max, logic [31:0] tag, output bit hit);
    int n;
    int i;
    n = is_max ? hi_n : lo_n;
    i = find_slot(is_max, n, tag);
    hit = (i < n);
    if (!hit) return;
    n--;
    if (is_max) begin
      hi_heap[i] = hi_heap[n]; hi_n = n;
    end else begin
      lo_heap[i] = lo_heap[n]; lo_n = n;
    end
    if (i != n) resift(is_max, n, i);
  endtask

  // apply one command to the model and return the result beat it yields
  task automatic predict_queue(input req_t c, output rsp_t r);
    int i;
    int j;
    bit hit;
    r = '0;
    r.status = STATUS_DONE;
    case (c.func)
      FUNC_INSERT: begin
        if (hi_n >= DEPTH || lo_n >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          lo_heap[lo_n] = '{c.tag, c.priority_req}; lo_n++;
          resift(1'b0, lo_n, lo_n - 1);
          hi_heap[hi_n] = '{c.tag, c.priority_req}; hi_n++;
          resift(1'b1, hi_n, hi_n - 1);
        end
      end
      FUNC_UPDATE: begin
        i = find_slot(1'b0, lo_n, c.tag);
        j = find_slot(1'b1, hi_n, c.tag);
        if (i < lo_n) begin
          lo_heap[i].prio = c.priority_req; resift(1'b0, lo_n, i);
        end
        if (j < hi_n) begin
          hi_heap[j].prio = c.priority_req; resift(1'b1, hi_n, j);
        end
        if (i >= lo_n && j >= hi_n) r.status = STATUS_NOT_FOUND;
      end
      FUNC_REM_MAX: begin
        drop_tag(1'b1, c.tag, hit);
        if (!hit) r.status = STATUS_NOT_FOUND;
      end
      default: begin
        drop_tag(1'b0, c.tag, hit);
        if (!hit) r.status = STATUS_NOT_FOUND;
      end
    endcase
    if (hi_n > 0) begin
      r.max_tag = hi_heap[0].tag; r.max_priority = hi_heap[0].prio; r.max_valid = 1'b1;
    end
    if (lo_n > 0) begin
      r.min_tag = lo_heap[0].tag; r.min_priority = lo_heap[0].prio; r.min_valid = 1'b1;
    end
    r.is_full = (hi_n >= DEPTH && lo_n >= DEPTH);
    r.is_empty = (hi_n == 0 && lo_n == 0);
  endtask

  task automatic report_mismatch(string what, rsp_t got, rsp_t want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result side: every done beat is compared with the oldest expectation
  always @(posedge clk) begin
    rsp_t w;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat", result, '0);
      end else begin
        w = pending_rsp.pop_front();
        if (result !== w) report_mismatch("result beat", result, w);
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sender gaps: random bursts of idle cycles before about one beat in four, unless quiet
  bit quiet = 1'b0;

  task automatic send_beat(input req_t c, input bit use_typed, input rsp_t typed_rsp);
    rsp_t r;
    if (!quiet && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 19)) @(posedge clk);
    req <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // accepted at this edge: start high and busy low
    predict_queue(c, r);
    if (use_typed) r = typed_rsp;
    pending_rsp.push_back(r);
    start <= 1'b0;
    // wait for the beat so start is never sampled again while busy is still low
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic req_t mk(logic [1:0] f, logic [31:0] t, logic [15:0] p);
    req_t c;
    c.func = f; c.tag = t; c.priority_req = p;
    return c;
  endfunction

  function automatic logic [31:0] pick_tag();
    if (live_tags.size() > 0 && $urandom_range(0, 9) < 8)
      return live_tags[$urandom_range(0, live_tags.size() - 1)];
    if ($urandom_range(0, 1)) return $urandom_range(0, 15);
    return $urandom();
  endfunction

  row_t dir_rows[$];
  rsp_t empty_rsp;
  rsp_t typed;

  initial begin
    req_t c;
    int kind;
    empty_rsp = '0;
    empty_rsp.is_empty = 1'b1;
    hi_n = 0;
    lo_n = 0;

    // directed table: empty-queue error cases and a first insert, with results typed in
    typed = empty_rsp; typed.status = STATUS_NOT_FOUND;
    dir_rows.push_back('{mk(FUNC_UPDATE, 32'h1, 16'h5), 1'b1, typed});
    dir_rows.push_back('{mk(FUNC_REM_MAX, 32'h1, 16'h0), 1'b1, typed});
    dir_rows.push_back('{mk(FUNC_REM_MIN, 32'hffff_ffff, 16'hffff), 1'b1, typed});
    typed = '0;
    typed.max_tag = 32'hffff_ffff; typed.max_priority = 16'hffff; typed.max_valid = 1'b1;
    typed.min_tag = 32'hffff_ffff; typed.min_priority = 16'hffff; typed.min_valid = 1'b1;
    dir_rows.push_back('{mk(FUNC_INSERT, 32'hffff_ffff, 16'hffff), 1'b1, typed});
    dir_rows.push_back('{mk(FUNC_INSERT, 32'h0, 16'h0), 1'b0, empty_rsp});
    // duplicate tag and equal priorities
    dir_rows.push_back('{mk(FUNC_INSERT, 32'h0, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_INSERT, 32'h7, 16'h8000), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_UPDATE, 32'h0, 16'h9000), 1'b0, empty_rsp});
    // tag only in the min heap after removal from the max heap
    dir_rows.push_back('{mk(FUNC_REM_MAX, 32'h7, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_UPDATE, 32'h7, 16'h1), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_REM_MIN, 32'h7, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_UPDATE, 32'h7, 16'h1), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_REM_MIN, 32'hffff_ffff, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_REM_MAX, 32'h0, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_REM_MAX, 32'h0, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_REM_MIN, 32'h0, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_REM_MIN, 32'h0, 16'h0), 1'b0, empty_rsp});
    dir_rows.push_back('{mk(FUNC_REM_MAX, 32'hffff_ffff, 16'h0), 1'b0, empty_rsp});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // typed rows are checked against the typed value, the rest against the model
    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].cmd, dir_rows[k].has_rsp, dir_rows[k].rsp);
    end

    // random part: mostly inserts and operations on live tags; fill to full twice
    for (int n = 0; n < 1250; n++) begin
      if (n > 1100) quiet = 1'b1;
      kind = $urandom_range(0, 99);
      if ((n % 400) < 90 && n > 100 && n < 900) kind = 0; // drive toward full
      else if ((n % 400) < 170 && n > 100 && n < 900) kind = 60 + kind % 40;
      if (kind < 35) begin
        c = mk(FUNC_INSERT, pick_tag(), 16'($urandom()));
        if ($urandom_range(0, 5) == 0) c.priority_req = 16'($urandom_range(0, 3));
        live_tags.push_back(c.tag);
      end else if (kind < 60) begin
        c = mk(FUNC_UPDATE, pick_tag(), 16'($urandom()));
      end else if (kind < 80) begin
        c = mk(FUNC_REM_MAX, pick_tag(), 16'($urandom()));
      end else begin
        c = mk(FUNC_REM_MIN, pick_tag(), 16'($urandom()));
      end
      if (live_tags.size() > 200) live_tags.delete(0);
      send_beat(c, 1'b0, empty_rsp);
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+design
design/dhpq_pkg.sv
design/dhpq_heap.sv
design/dhpq_ctrl.sv
design/dual_heap_priority_queue.sv
test/tb_dual_heap_priority_queue.sv
